@@ rtl/bcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg
// Types and constants shared by the button click detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned DEB_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TIMEOUT = 2'd2;

    localparam logic [DEB_W-1:0]  DEBOUNCE_TIME_RST = 8'd50;
    localparam logic [TICK_W-1:0] CLICK_TIMEOUT_RST = 16'd400;
    localparam logic [TICK_W-1:0] PRESS_TIMEOUT_RST = 16'd800;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef struct packed {
        logic [TICK_W-1:0] now_ticks;
        logic              active_level;
    } t_bcd_in;

    typedef struct packed {
        logic [1:0] event_res;
        logic       debounced_level;
    } t_bcd_out;

endpackage

@@ rtl/button_click_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_detector_unit
// Debounces a button level and reports single click, double click and
// long press start, at most one event per tick item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  input     in         i_valid / o_stall       i_item  (t_bcd_in)
//  output    out        o_valid / i_stall       o_item  (t_bcd_out)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One item per cycle while the output side does not stall; each item passes
//  the input register, then the state update and result register.
//  Reset is synchronous, active low; it clears state, handshake flags and
//  loads the default timing registers.
//  o_stall rises only while both the input and result registers are full
//  and the output side stalls.
// ----------------------------------------------------------------------------
module button_click_detector_unit
    import bcd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_bcd_in              i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_bcd_out             o_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DOWN     = 3'd1,
        ST_UP       = 3'd2,
        ST_COUNT    = 3'd3,
        ST_PRESS    = 3'd4,
        ST_PRESSEND = 3'd5
    } t_state;

    logic [DEB_W-1:0]  r_debounce_time;
    logic [TICK_W-1:0] r_click_timeout;
    logic [TICK_W-1:0] r_press_timeout;

    logic              r_in_valid;
    t_bcd_in           r_in;
    logic              r_out_valid;
    t_bcd_out          r_out;

    t_state            r_state,  n_state;
    logic [1:0]        r_count,  n_count;
    logic [TICK_W-1:0] r_start,  n_start;
    logic [TICK_W-1:0] r_bounce, n_bounce;
    logic              r_prev,   n_prev;
    logic              r_stable, n_stable;
    t_event            n_event;

    logic              out_blocked;
    logic              advance;
    logic              in_take;
    logic [TICK_W-1:0] held;
    logic [TICK_W-1:0] since_start;
    logic [TICK_W-1:0] wait_ms;

    assign out_blocked = r_out_valid && i_stall;
    assign advance     = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;
    assign in_take     = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;
    assign o_cfg_ready = 1'b1;

    assign held        = r_in.now_ticks - r_bounce;
    assign since_start = r_in.now_ticks - r_start;
    assign wait_ms     = {since_start[TICK_W-3:0], 2'b00};

    always_comb begin
        n_bounce = r_bounce;
        n_prev   = r_prev;
        n_stable = r_stable;
        if (r_prev == r_in.active_level) begin
            if (held >= TICK_W'(r_debounce_time >> 2)) begin
                n_stable = r_in.active_level;
            end
        end else begin
            n_bounce = r_in.now_ticks;
            n_prev   = r_in.active_level;
        end

        n_state = r_state;
        n_count = r_count;
        n_start = r_start;
        n_event = EV_NONE;
        case (r_state)
            ST_IDLE: begin
                if (n_stable) begin
                    n_state = ST_DOWN;
                    n_start = r_in.now_ticks;
                    n_count = 2'd0;
                end
            end
            ST_DOWN: begin
                if (!n_stable) begin
                    n_state = ST_UP;
                    n_start = r_in.now_ticks;
                end else if (wait_ms > r_press_timeout) begin
                    n_event = EV_LONG;
                    n_state = ST_PRESS;
                end
            end
            ST_UP: begin
                if (r_count != 2'd3) begin
                    n_count = r_count + 2'd1;
                end
                n_state = ST_COUNT;
            end
            ST_COUNT: begin
                if (n_stable) begin
                    n_state = ST_DOWN;
                    n_start = r_in.now_ticks;
                end else if (wait_ms >= r_click_timeout || r_count >= 2'd2) begin
                    if (r_count == 2'd1) begin
                        n_event = EV_SINGLE;
                    end else if (r_count >= 2'd2) begin
                        n_event = EV_DOUBLE;
                    end
                    n_state = ST_IDLE;
                    n_count = 2'd0;
                    n_start = '0;
                end
            end
            ST_PRESS: begin
                if (!n_stable) begin
                    n_state = ST_PRESSEND;
                    n_start = r_in.now_ticks;
                end
            end
            default: begin
                // press end and unused codes
                n_state = ST_IDLE;
                n_count = 2'd0;
                n_start = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= DEBOUNCE_TIME_RST;
            r_click_timeout <= CLICK_TIMEOUT_RST;
            r_press_timeout <= PRESS_TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TIME: r_debounce_time <= i_cfg_data[DEB_W-1:0];
                CFG_CLICK_TIMEOUT: r_click_timeout <= i_cfg_data;
                CFG_PRESS_TIMEOUT: r_press_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= ST_IDLE;
            r_count     <= 2'd0;
            r_start     <= '0;
            r_bounce    <= '0;
            r_prev      <= 1'b0;
            r_stable    <= 1'b0;
        end else begin
            if (!out_blocked) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state  <= n_state;
                r_count  <= n_count;
                r_start  <= n_start;
                r_bounce <= n_bounce;
                r_prev   <= n_prev;
                r_stable <= n_stable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.event_res       <= n_event;
            r_out.debounced_level <= n_stable;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while a register is free");

    a_long_in_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_LONG) |-> (r_state == ST_PRESS))
        else $error("long press reported outside press state");

    a_click_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_res == EV_SINGLE || r_out.event_res == EV_DOUBLE))
        |-> (r_state == ST_IDLE && r_count == 2'd0))
        else $error("click reported without return to idle");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_count == 2'd0 && r_start == '0))
        else $error("idle with stale count or start time");

    a_level_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.debounced_level == r_stable))
        else $error("reported level differs from debounced state");

endmodule
